// ===== rtl/tcwe_pkg.sv =====
package tcwe_pkg;

   localparam int SCREEN_COLUMNS_DEF = 80;
   localparam int SCREEN_ROWS_DEF    = 25;

   // working widths for window edge arithmetic (left + width, top + height)
   localparam int COL_MW = 9;
   localparam int ROW_MW = 7;

   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 48;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   localparam logic [7:0] BLANK_CHAR = 8'h20;

   localparam logic [6:0] LEFT_RST   = 7'd0;
   localparam logic [4:0] TOP_RST    = 5'd0;
   localparam logic [6:0] WIDTH_RST  = 7'd80;
   localparam logic [4:0] HEIGHT_RST = 5'd25;
   localparam logic [6:0] HTAB_RST   = 7'd8;
   localparam logic [4:0] VTAB_RST   = 5'd1;
   localparam logic [7:0] ATTR_RST   = 8'd7;

   typedef enum logic [3:0] {
      ACT_WRITE      = 4'd0,
      ACT_WRITE_DOWN = 4'd1,
      ACT_BEL        = 4'd2,
      ACT_BS         = 4'd3,
      ACT_HT         = 4'd4,
      ACT_LF         = 4'd5,
      ACT_VT         = 4'd6,
      ACT_CR         = 4'd7,
      ACT_DEL        = 4'd8,
      ACT_MOVE       = 4'd9,
      ACT_NOP        = 4'd10
   } action_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CFG_WINDOW_LEFT   = 3'd0,
      CFG_WINDOW_TOP    = 3'd1,
      CFG_WINDOW_WIDTH  = 3'd2,
      CFG_WINDOW_HEIGHT = 3'd3,
      CFG_TAB_COLUMNS   = 3'd4,
      CFG_TAB_ROWS      = 3'd5,
      CFG_TEXT_ATTR     = 3'd6
   } cfg_index_type;

   typedef enum logic [2:0] {
      OP_NONE = 3'd0,
      OP_ADV  = 3'd1,
      OP_LF   = 3'd2,
      OP_BS   = 3'd3,
      OP_CR   = 3'd4,
      OP_MOVE = 3'd5
   } op_type;

   typedef struct packed {
      logic   load;       // capture the request, clear the result record
      logic   rec;        // record the cell at the cursor before op
      logic   rec_blank;  // recorded cell gets a space
      logic   bell;
      op_type op;
      logic   publish;    // move record and cursor into the response register
   } cmd_type;

   typedef struct packed {
      logic [3:0] action;
      logic [6:0] tab_count;
   } status_type;

endpackage

// ===== rtl/tcwe_ctrl.sv =====
module tcwe_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  tcwe_pkg::status_type status,
   output tcwe_pkg::cmd_type    cmd
);
   import tcwe_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STEP1,
      ST_STEP2,
      ST_STEP3,
      ST_LOOP,
      ST_DONE
   } state_type;

   state_type  state_ff, state_in;
   logic [6:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;
   logic       is_tab;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign is_tab     = (status.action == ACT_HT) || (status.action == ACT_VT);

   always_comb begin
      cmd    = '0;
      cmd.op = OP_NONE;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = req_tvalid;
         end
         ST_STEP1: begin
            case (status.action)
               ACT_WRITE: begin
                  cmd.rec = 1'b1;
                  cmd.op  = OP_ADV;
               end
               ACT_WRITE_DOWN: begin
                  cmd.rec = 1'b1;
                  cmd.op  = OP_LF;
               end
               ACT_BEL:  cmd.bell = 1'b1;
               ACT_BS:   cmd.op = OP_BS;
               ACT_LF:   cmd.op = OP_LF;
               ACT_CR:   cmd.op = OP_CR;
               ACT_DEL:  cmd.op = OP_BS;
               ACT_MOVE: cmd.op = OP_MOVE;
               default:  cmd.op = OP_NONE;
            endcase
         end
         ST_STEP2: begin
            // DEL: blank the cell, then advance (may wrap a line)
            cmd.rec       = 1'b1;
            cmd.rec_blank = 1'b1;
            cmd.op        = OP_ADV;
         end
         ST_STEP3: begin
            cmd.op = OP_BS;
         end
         ST_LOOP: begin
            if (cnt_ff != 7'd0) begin
               cmd.op = (status.action == ACT_HT) ? OP_ADV : OP_LF;
            end
         end
         ST_DONE: begin
            cmd.publish = out_free;
         end
         default: cmd.op = OP_NONE;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_STEP1;
            end
         end
         ST_STEP1: begin
            if (is_tab) begin
               cnt_in   = status.tab_count;
               state_in = ST_LOOP;
            end else if (status.action == ACT_DEL) begin
               state_in = ST_STEP2;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_STEP2: state_in = ST_STEP3;
         ST_STEP3: state_in = ST_DONE;
         ST_LOOP: begin
            if (cnt_ff == 7'd0) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff - 7'd1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= 7'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/tcwe_datapath.sv =====
module tcwe_datapath #(
   parameter int SCREEN_COLUMNS = tcwe_pkg::SCREEN_COLUMNS_DEF,
   parameter int SCREEN_ROWS    = tcwe_pkg::SCREEN_ROWS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [tcwe_pkg::REQ_TDATA_W-1:0]    req_tdata,
   output logic [tcwe_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  logic                                csr_wr_en,
   input  logic [tcwe_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tcwe_pkg::CSR_DATA_W-1:0]     csr_wr_data,
   input  tcwe_pkg::cmd_type                   cmd,
   output tcwe_pkg::status_type                status
);
   import tcwe_pkg::*;

   localparam int CW  = $clog2(SCREEN_COLUMNS);
   localparam int RW  = $clog2(SCREEN_ROWS);
   localparam int CHW = CW + 1;
   localparam int RHW = RW + 1;

   function automatic logic [CW-1:0] col_sat(input logic [6:0] v);
      if (COL_MW'(v) > COL_MW'(SCREEN_COLUMNS - 1)) begin
         return CW'(SCREEN_COLUMNS - 1);
      end
      return CW'(v);
   endfunction

   function automatic logic [RW-1:0] row_sat(input logic [4:0] v);
      if (ROW_MW'(v) > ROW_MW'(SCREEN_ROWS - 1)) begin
         return RW'(SCREEN_ROWS - 1);
      end
      return RW'(v);
   endfunction

   // configuration
   logic [6:0] left_ff, left_in, width_ff, width_in, htab_ff, htab_in;
   logic [4:0] top_ff, top_in, height_ff, height_in, vtab_ff, vtab_in;
   logic [7:0] attr_ff, attr_in;
   logic       home;

   // window edges, refreshed every cycle from the configuration
   logic [CW-1:0]  col_lo_ff;
   logic [CHW-1:0] col_hi_ff;
   logic [RW-1:0]  row_lo_ff;
   logic [RHW-1:0] row_hi_ff;
   logic [6:0]     col_span;
   logic [4:0]     row_span;
   logic [COL_MW-1:0] col_end;
   logic [ROW_MW-1:0] row_end;

   // captured request
   logic [3:0] action_ff;
   logic [7:0] char_ff;
   logic [6:0] tcol_ff;
   logic [4:0] trow_ff;

   // cursor
   logic [CW-1:0] cur_col_ff, cur_col_in;
   logic [RW-1:0] cur_row_ff, cur_row_in;

   // result record
   logic          rec_valid_ff;
   logic [7:0]    rec_char_ff;
   logic [7:0]    rec_attr_ff;
   logic [CW-1:0] rec_col_ff;
   logic [RW-1:0] rec_row_ff;
   logic          bell_ff;
   logic          merr_ff;

   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   logic [CHW-1:0] col_p1;
   logic [RHW-1:0] row_p1;
   logic [RW-1:0]  lf_row;
   logic           adv_wrap;
   logic           move_in;

   assign status.action    = action_ff;
   assign status.tab_count = (action_ff == ACT_HT) ? htab_ff : 7'(vtab_ff);

   always_comb begin
      left_in   = left_ff;
      top_in    = top_ff;
      width_in  = width_ff;
      height_in = height_ff;
      htab_in   = htab_ff;
      vtab_in   = vtab_ff;
      attr_in   = attr_ff;
      home      = 1'b0;
      if (csr_wr_en) begin
         case (csr_index)
            CFG_WINDOW_LEFT: begin
               left_in = csr_wr_data[6:0];
               home    = 1'b1;
            end
            CFG_WINDOW_TOP: begin
               top_in = csr_wr_data[4:0];
               home   = 1'b1;
            end
            CFG_WINDOW_WIDTH: begin
               width_in = csr_wr_data[6:0];
               home     = 1'b1;
            end
            CFG_WINDOW_HEIGHT: begin
               height_in = csr_wr_data[4:0];
               home      = 1'b1;
            end
            CFG_TAB_COLUMNS: htab_in = csr_wr_data[6:0];
            CFG_TAB_ROWS:    vtab_in = csr_wr_data[4:0];
            CFG_TEXT_ATTR:   attr_in = csr_wr_data;
            default:         home    = 1'b0;
         endcase
      end
   end

   always_comb begin
      col_span = (width_ff == 7'd0) ? 7'd1 : width_ff;
      row_span = (height_ff == 5'd0) ? 5'd1 : height_ff;
      col_end  = COL_MW'(col_sat(left_ff)) + COL_MW'(col_span);
      row_end  = ROW_MW'(row_sat(top_ff)) + ROW_MW'(row_span);
   end

   always_ff @(posedge clock) begin
      col_lo_ff <= col_sat(left_ff);
      row_lo_ff <= row_sat(top_ff);
      col_hi_ff <= (col_end > COL_MW'(SCREEN_COLUMNS)) ? CHW'(SCREEN_COLUMNS) : CHW'(col_end);
      row_hi_ff <= (row_end > ROW_MW'(SCREEN_ROWS)) ? RHW'(SCREEN_ROWS) : RHW'(row_end);
   end

   always_comb begin
      col_p1   = CHW'(cur_col_ff) + CHW'(1);
      row_p1   = RHW'(cur_row_ff) + RHW'(1);
      adv_wrap = (col_p1 >= col_hi_ff);
      lf_row   = (row_p1 >= row_hi_ff) ? row_lo_ff : RW'(row_p1);
      move_in  = (COL_MW'(tcol_ff) >= COL_MW'(col_lo_ff)) &&
                 (COL_MW'(tcol_ff) <  COL_MW'(col_hi_ff)) &&
                 (ROW_MW'(trow_ff) >= ROW_MW'(row_lo_ff)) &&
                 (ROW_MW'(trow_ff) <  ROW_MW'(row_hi_ff));

      cur_col_in = cur_col_ff;
      cur_row_in = cur_row_ff;
      case (cmd.op)
         OP_ADV: begin
            if (adv_wrap) begin
               cur_col_in = col_lo_ff;
               cur_row_in = lf_row;
            end else begin
               cur_col_in = CW'(col_p1);
            end
         end
         OP_LF: cur_row_in = lf_row;
         OP_BS: begin
            if (cur_col_ff > col_lo_ff) begin
               cur_col_in = cur_col_ff - CW'(1);
            end
         end
         OP_CR: cur_col_in = col_lo_ff;
         OP_MOVE: begin
            if (move_in) begin
               cur_col_in = CW'(tcol_ff);
               cur_row_in = RW'(trow_ff);
            end
         end
         default: cur_col_in = cur_col_ff;
      endcase
      // new window geometry homes the cursor
      if (home) begin
         cur_col_in = col_sat(left_in);
         cur_row_in = row_sat(top_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff    <= LEFT_RST;
         top_ff     <= TOP_RST;
         width_ff   <= WIDTH_RST;
         height_ff  <= HEIGHT_RST;
         htab_ff    <= HTAB_RST;
         vtab_ff    <= VTAB_RST;
         attr_ff    <= ATTR_RST;
         cur_col_ff <= col_sat(LEFT_RST);
         cur_row_ff <= row_sat(TOP_RST);
      end else begin
         left_ff    <= left_in;
         top_ff     <= top_in;
         width_ff   <= width_in;
         height_ff  <= height_in;
         htab_ff    <= htab_in;
         vtab_ff    <= vtab_in;
         attr_ff    <= attr_in;
         cur_col_ff <= cur_col_in;
         cur_row_ff <= cur_row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff    <= req_tdata[3:0];
         char_ff      <= req_tdata[11:4];
         tcol_ff      <= req_tdata[18:12];
         trow_ff      <= req_tdata[23:19];
         rec_valid_ff <= 1'b0;
         rec_char_ff  <= 8'd0;
         rec_attr_ff  <= 8'd0;
         rec_col_ff   <= '0;
         rec_row_ff   <= '0;
         bell_ff      <= 1'b0;
         merr_ff      <= 1'b0;
      end else begin
         if (cmd.rec) begin
            rec_valid_ff <= 1'b1;
            rec_char_ff  <= cmd.rec_blank ? BLANK_CHAR : char_ff;
            rec_attr_ff  <= attr_ff;
            rec_col_ff   <= cur_col_ff;
            rec_row_ff   <= cur_row_ff;
         end
         if (cmd.bell) begin
            bell_ff <= 1'b1;
         end
         if (cmd.op == OP_MOVE && !move_in) begin
            merr_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_data_ff <= {5'd0, merr_ff, bell_ff, 5'(cur_row_ff), 7'(cur_col_ff),
                         5'(rec_row_ff), 7'(rec_col_ff), rec_attr_ff, rec_char_ff,
                         rec_valid_ff};
      end
   end

   assign rsp_tdata = rsp_data_ff;

endmodule

// ===== rtl/text_window_cursor_engine_unit.sv =====
// Channel   Ports                          Payload
// request   req_tvalid/req_tready/tdata    action, char_code, target_column, target_row
// response  rsp_tvalid/rsp_tready/tdata    write cell, cursor position, bell, move_error
// config    csr_wr_en/csr_index/wr_data    register write, no read-back
//
// One item at a time: a new request is accepted only after the previous item has been
// published. DEL runs a back-up, a blank-and-advance and a back-up step, and HT and VT
// run one cursor step per cycle in the datapath.
// Reset clears the configuration to its defaults and homes the cursor to (0, 0).
// A waiting response does not block the next request; it holds in the output
// register and only the publish step of the following item waits for it to drain.
module text_window_cursor_engine_unit #(
   parameter int SCREEN_COLUMNS = tcwe_pkg::SCREEN_COLUMNS_DEF,
   parameter int SCREEN_ROWS    = tcwe_pkg::SCREEN_ROWS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // action[3:0], char_code[11:4], target_column[18:12], target_row[23:19]
   input  logic [tcwe_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // write_valid[0], write_char[8:1], write_attr[16:9], write_column[23:17],
   // write_row[28:24], cursor_column[35:29], cursor_row[40:36], bell[41],
   // move_error[42], zero fill above
   output logic [tcwe_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                             csr_wr_en,
   input  logic [tcwe_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tcwe_pkg::CSR_DATA_W-1:0]  csr_wr_data
);
   import tcwe_pkg::*;

   cmd_type    cmd;
   status_type status;

   tcwe_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tcwe_datapath #(
      .SCREEN_COLUMNS (SCREEN_COLUMNS),
      .SCREEN_ROWS    (SCREEN_ROWS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

// ===== tb/text_window_cursor_engine_unit_tb.sv =====
module text_window_cursor_engine_unit_tb;
   import tcwe_pkg::*;

   localparam int SCR_COLS        = SCREEN_COLUMNS_DEF;
   localparam int SCR_ROWS        = SCREEN_ROWS_DEF;
   localparam int QUIET_LIMIT     = 4000;
   localparam int TAIL_CYCLES     = 200;
   localparam int HOLD_CYCLES     = 80;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 54;
   localparam int REPORT_MAX      = 10;
   localparam logic [3:0] ACT_CODE_TOP = 4'hF;

   typedef struct packed {
      logic [4:0] target_row;
      logic [6:0] target_column;
      logic [7:0] char_code;
      logic [3:0] action;
   } cursor_req_type;

   typedef struct packed {
      logic       move_error;
      logic       bell;
      logic [4:0] cursor_row;
      logic [6:0] cursor_column;
      logic [4:0] write_row;
      logic [6:0] write_column;
      logic [7:0] write_attr;
      logic [7:0] write_char;
      logic       write_valid;
   } cell_result_type;

   localparam int CELL_W = $bits(cell_result_type);

   typedef struct {
      cursor_req_type  rq;
      bit              typed;
      cell_result_type want;
   } plan_row_type;

   logic                   clock;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata   = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_wr_en   = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_wr_data = '0;

   text_window_cursor_engine_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // shadow of the block: window registers and cursor
   int cfg_left   = LEFT_RST;
   int cfg_top    = TOP_RST;
   int cfg_width  = WIDTH_RST;
   int cfg_height = HEIGHT_RST;
   int cfg_htab   = HTAB_RST;
   int cfg_vtab   = VTAB_RST;
   logic [7:0] cfg_attr = ATTR_RST;
   int cur_col = 0;
   int cur_row = 0;

   cell_result_type cell_q[$];
   plan_row_type    plan_q[$];
   int fail_count     = 0;
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   bit hold_go        = 1'b0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int sat_origin(int origin, int screen);
      return (origin > screen - 1) ? screen - 1 : origin;
   endfunction

   function automatic int sat_end(int origin, int size, int screen);
      int stop;
      stop = sat_origin(origin, screen) + ((size == 0) ? 1 : size);
      return (stop > screen) ? screen : stop;
   endfunction

   function automatic void home_cursor();
      cur_col = sat_origin(cfg_left, SCR_COLS);
      cur_row = sat_origin(cfg_top, SCR_ROWS);
   endfunction

   function automatic void feed_line(inout int row, input int tp, input int btm);
      row++;
      if (row >= btm) row = tp;
   endfunction

   function automatic void step_right(inout int col, inout int row,
                                      input int lft, input int rgt,
                                      input int tp, input int btm);
      col++;
      if (col >= rgt) begin
         col = lft;
         feed_line(row, tp, btm);
      end
   endfunction

   function automatic void apply_cfg(cfg_index_type idx, logic [7:0] v);
      case (idx)
         CFG_WINDOW_LEFT: begin
            cfg_left = v[6:0];
            home_cursor();
         end
         CFG_WINDOW_TOP: begin
            cfg_top = v[4:0];
            home_cursor();
         end
         CFG_WINDOW_WIDTH: begin
            cfg_width = v[6:0];
            home_cursor();
         end
         CFG_WINDOW_HEIGHT: begin
            cfg_height = v[4:0];
            home_cursor();
         end
         CFG_TAB_COLUMNS: cfg_htab = v[6:0];
         CFG_TAB_ROWS:    cfg_vtab = v[4:0];
         CFG_TEXT_ATTR:   cfg_attr = v;
         default: ;
      endcase
   endfunction

   function automatic cell_result_type predict_cell(cursor_req_type rq);
      cell_result_type r;
      int lft, rgt, tp, btm;
      lft = sat_origin(cfg_left, SCR_COLS);
      rgt = sat_end(cfg_left, cfg_width, SCR_COLS);
      tp  = sat_origin(cfg_top, SCR_ROWS);
      btm = sat_end(cfg_top, cfg_height, SCR_ROWS);
      r = '0;
      case (rq.action)
         ACT_WRITE, ACT_WRITE_DOWN: begin
            r.write_valid  = 1'b1;
            r.write_char   = rq.char_code;
            r.write_attr   = cfg_attr;
            r.write_column = 7'(cur_col);
            r.write_row    = 5'(cur_row);
            if (rq.action == ACT_WRITE) step_right(cur_col, cur_row, lft, rgt, tp, btm);
            else feed_line(cur_row, tp, btm);
         end
         ACT_BEL: r.bell = 1'b1;
         ACT_BS: if (cur_col > lft) cur_col--;
         ACT_HT: for (int i = 0; i < cfg_htab; i++)
            step_right(cur_col, cur_row, lft, rgt, tp, btm);
         ACT_LF: feed_line(cur_row, tp, btm);
         ACT_VT: for (int i = 0; i < cfg_vtab; i++) feed_line(cur_row, tp, btm);
         ACT_CR: cur_col = lft;
         ACT_DEL: begin
            // back up, blank the cell, then advance and back up again; a wrapping advance is not undone
            if (cur_col > lft) cur_col--;
            r.write_valid  = 1'b1;
            r.write_char   = BLANK_CHAR;
            r.write_attr   = cfg_attr;
            r.write_column = 7'(cur_col);
            r.write_row    = 5'(cur_row);
            step_right(cur_col, cur_row, lft, rgt, tp, btm);
            if (cur_col > lft) cur_col--;
         end
         ACT_MOVE: begin
            if (rq.target_column >= lft && rq.target_column < rgt &&
                rq.target_row >= tp && rq.target_row < btm) begin
               cur_col = rq.target_column;
               cur_row = rq.target_row;
            end else begin
               r.move_error = 1'b1;
            end
         end
         default: ;
      endcase
      r.cursor_column = 7'(cur_col);
      r.cursor_row    = 5'(cur_row);
      return r;
   endfunction

   function automatic cursor_req_type mk_req(logic [3:0] act, logic [7:0] ch,
                                             logic [6:0] tc, logic [4:0] tr);
      cursor_req_type rq;
      rq.action        = act;
      rq.char_code     = ch;
      rq.target_column = tc;
      rq.target_row    = tr;
      return rq;
   endfunction

   function automatic cell_result_type mk_cell(logic wv, logic [7:0] ch, logic [7:0] at,
                                               logic [6:0] wc, logic [4:0] wr,
                                               logic [6:0] cc, logic [4:0] cr,
                                               logic bl, logic me);
      cell_result_type c;
      c.write_valid   = wv;
      c.write_char    = ch;
      c.write_attr    = at;
      c.write_column  = wc;
      c.write_row     = wr;
      c.cursor_column = cc;
      c.cursor_row    = cr;
      c.bell          = bl;
      c.move_error    = me;
      return c;
   endfunction

   function automatic void add_row(cursor_req_type rq, bit typed = 1'b0,
                                   cell_result_type want = '0);
      plan_row_type row;
      row.rq    = rq;
      row.typed = typed;
      row.want  = want;
      plan_q.push_back(row);
   endfunction

   function automatic string show_cell(cell_result_type c);
      return $sformatf({"wv=%0b ch=%02h attr=%02h cell=(%0d,%0d) ",
                        "cursor=(%0d,%0d) bell=%0b merr=%0b"},
                       c.write_valid, c.write_char, c.write_attr, c.write_column,
                       c.write_row, c.cursor_column, c.cursor_row, c.bell, c.move_error);
   endfunction

   function automatic void check_cell(logic [RSP_TDATA_W-1:0] data);
      cell_result_type got, want;
      got = data[CELL_W-1:0];
      if (cell_q.size() == 0) begin
         fail_count++;
         if (fail_count <= REPORT_MAX)
            $display("unexpected response transaction: %s", show_cell(got));
      end else begin
         want = cell_q.pop_front();
         if (got !== want || data[RSP_TDATA_W-1:CELL_W] !== '0) begin
            fail_count++;
            if (fail_count <= REPORT_MAX) begin
               $display("mismatch at %0t:", $realtime);
               $display("  expected %s fill=0", show_cell(want));
               $display("  actual   %s fill=%0h", show_cell(got),
                        data[RSP_TDATA_W-1:CELL_W]);
            end
         end
      end
   endfunction

   function automatic cursor_req_type random_request();
      cursor_req_type rq;
      int pick, lft, rgt, tp, btm;
      lft = sat_origin(cfg_left, SCR_COLS);
      rgt = sat_end(cfg_left, cfg_width, SCR_COLS);
      tp  = sat_origin(cfg_top, SCR_ROWS);
      btm = sat_end(cfg_top, cfg_height, SCR_ROWS);
      rq = mk_req(ACT_NOP, 8'($urandom), 7'($urandom), 5'($urandom));
      pick = $urandom_range(99);
      if (pick < 30)      rq.action = ACT_WRITE;
      else if (pick < 40) rq.action = ACT_WRITE_DOWN;
      else if (pick < 44) rq.action = ACT_BEL;
      else if (pick < 52) rq.action = ACT_BS;
      else if (pick < 58) rq.action = ACT_HT;
      else if (pick < 64) rq.action = ACT_LF;
      else if (pick < 68) rq.action = ACT_VT;
      else if (pick < 74) rq.action = ACT_CR;
      else if (pick < 82) rq.action = ACT_DEL;
      else if (pick < 95) rq.action = ACT_MOVE;
      else rq.action = 4'($urandom_range(ACT_NOP, ACT_CODE_TOP));
      // most moves land inside the window
      if (rq.action == ACT_MOVE && $urandom_range(99) < 70) begin
         rq.target_column = 7'(lft + $urandom_range(rgt - lft - 1));
         rq.target_row    = 5'(tp + $urandom_range(btm - tp - 1));
      end
      return rq;
   endfunction

   // returns at the edge where the transaction is accepted
   task automatic offer(cursor_req_type rq, bit typed = 1'b0, cell_result_type want = '0);
      cell_result_type pred;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rq;
      do @(posedge clock); while (!req_tready);
      pred = predict_cell(rq);
      cell_q.push_back(typed ? want : pred);
   endtask

   task automatic write_reg(cfg_index_type idx, logic [7:0] v);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= v;
      apply_cfg(idx, v);
      @(posedge clock);
   endtask

   task automatic configure(logic [7:0] lft, logic [7:0] tp, logic [7:0] wd,
                            logic [7:0] ht, logic [7:0] htab, logic [7:0] vtab,
                            logic [7:0] attr);
      write_reg(CFG_WINDOW_LEFT, lft);
      write_reg(CFG_WINDOW_TOP, tp);
      write_reg(CFG_WINDOW_WIDTH, wd);
      write_reg(CFG_WINDOW_HEIGHT, ht);
      write_reg(CFG_TAB_COLUMNS, htab);
      write_reg(CFG_TAB_ROWS, vtab);
      write_reg(CFG_TEXT_ATTR, attr);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_idling(int mode);
      case (mode)
         1: begin
            send_idle_pct  = 61;
            recv_stall_pct = 0;
         end
         2: begin
            send_idle_pct  = 0;
            recv_stall_pct = 61;
         end
         3: begin
            send_idle_pct  = 10;
            recv_stall_pct = 10;
         end
         default: begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end
      endcase
   endtask

   task automatic run_random(int count);
      for (int i = 0; i < count; i++) offer(random_request());
      req_tvalid <= 1'b0;
      while (cell_q.size() != 0) @(posedge clock);
   endtask

   // response side: check, then pick the next ready value
   int hold_left = 0;
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_cell(rsp_tdata);
      if (hold_go) begin
         hold_go   = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset window is the full screen, cursor at the origin
      add_row(mk_req(ACT_WRITE, 8'h00, 0, 0), 1'b1,
              mk_cell(1, 8'h00, ATTR_RST, 0, 0, 1, 0, 0, 0));
      add_row(mk_req(ACT_WRITE, 8'hFF, 0, 0), 1'b1,
              mk_cell(1, 8'hFF, ATTR_RST, 1, 0, 2, 0, 0, 0));
      add_row(mk_req(ACT_BEL, 8'h00, 0, 0), 1'b1,
              mk_cell(0, 8'h00, 8'h00, 0, 0, 2, 0, 1, 0));
      add_row(mk_req(ACT_MOVE, 8'h00, 79, 24), 1'b1,
              mk_cell(0, 8'h00, 8'h00, 0, 0, 79, 24, 0, 0));
      // last cell of the screen: advance wraps to the window origin
      add_row(mk_req(ACT_WRITE, 8'h41, 0, 0), 1'b1,
              mk_cell(1, 8'h41, ATTR_RST, 79, 24, 0, 0, 0, 0));
      add_row(mk_req(ACT_BS, 8'h00, 0, 0), 1'b1,
              mk_cell(0, 8'h00, 8'h00, 0, 0, 0, 0, 0, 0));
      add_row(mk_req(ACT_MOVE, 8'hFF, 7'h7F, 5'h1F), 1'b1,
              mk_cell(0, 8'h00, 8'h00, 0, 0, 0, 0, 0, 1));
      add_row(mk_req(ACT_HT, 8'h00, 0, 0));
      add_row(mk_req(ACT_VT, 8'h00, 0, 0));
      add_row(mk_req(ACT_LF, 8'h00, 0, 0));
      add_row(mk_req(ACT_CR, 8'h00, 0, 0));
      add_row(mk_req(ACT_WRITE_DOWN, 8'h5A, 0, 0));
      add_row(mk_req(ACT_DEL, 8'h00, 0, 0));
      add_row(mk_req(ACT_HT, 8'h00, 0, 0));
      add_row(mk_req(ACT_DEL, 8'h00, 0, 0));
      add_row(mk_req(ACT_NOP, 8'h00, 0, 0));
      add_row(mk_req(ACT_CODE_TOP, 8'hFF, 7'h7F, 5'h1F));
      add_row(mk_req(ACT_WRITE_DOWN, 8'h80, 7'h7F, 5'h1F));
      add_row(mk_req(ACT_MOVE, 8'h00, 0, 0));
      add_row(mk_req(ACT_MOVE, 8'h00, 79, 0));
      add_row(mk_req(ACT_HT, 8'h00, 0, 0));
      add_row(mk_req(ACT_MOVE, 8'h00, 0, 24));
      add_row(mk_req(ACT_VT, 8'h00, 0, 0));
      add_row(mk_req(ACT_DEL, 8'h00, 0, 0));

      set_idling(0);
      foreach (plan_q[i]) offer(plan_q[i].rq, plan_q[i].typed, plan_q[i].want);

      // long receiver hold while the sender keeps pushing
      hold_go = 1'b1;
      run_random(ITEMS_PER_PHASE);

      for (int ph = 1; ph < PHASES; ph++) begin
         case (ph)
            1: configure(79, 24, 80, 25, 80, 25, 8'hFF);
            2: configure(0, 0, 0, 0, 0, 0, 8'h00);
            3: configure(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h80);
            4: configure(10, 5, 20, 8, 3, 2, 8'h5A);
            7: configure(0, 0, 80, 25, 80, 25, 8'h70);
            default: configure(8'($urandom_range(79)), 8'($urandom_range(24)),
                               8'($urandom_range(1, 80)), 8'($urandom_range(1, 25)),
                               8'($urandom_range(12)), 8'($urandom_range(4)),
                               8'($urandom_range(255)));
         endcase
         set_idling(ph % 4);
         run_random(ITEMS_PER_PHASE);
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      fail_count += cell_q.size();
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
